FILE: src/binary_to_decimal_text_emitter_unit_defines.svh
// assertion macros for the binary to decimal text emitter
`ifndef BINARY_TO_DECIMAL_TEXT_EMITTER_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_TEXT_EMITTER_UNIT_DEFINES_SVH

// same-cycle implication, reset disables the check
`define B2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables the check
`define B2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/b2d_pkg.sv
// shared constants and types of the binary to decimal text emitter
`timescale 1ns / 1ps

package b2d_pkg;

	localparam int VALUE_W  = 32;
	localparam int CHAR_W   = 8;
	localparam int NUM_DIG  = 10;
	localparam int FRAC_DIG = 3;
	localparam int PTR_W    = $clog2(NUM_DIG);
	localparam int CNT_W    = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_DOT,
		KIND_NL
	} char_kind_t;

	typedef struct packed {
		logic       load;
		logic       conv_step;
		logic       ptr_start;
		logic       ptr_dec;
		logic       time_mode;
		logic       out_load;
		char_kind_t out_kind;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic conv_last;
		logic ptr_int_end;
		logic ptr_zero;
	} dp_status_t;

endpackage

FILE: src/b2d_datapath.sv
// datapath: shift-add bcd conversion, digit pointer and output character register
`timescale 1ns / 1ps

module b2d_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [b2d_pkg::VALUE_W-1:0]    value,
	input  b2d_pkg::dp_cmd_t               cmd,
	output b2d_pkg::dp_status_t            status,
	output logic [b2d_pkg::CHAR_W-1:0]     text_char,
	output logic                           last_char
);

	logic [b2d_pkg::VALUE_W-1:0] bin_q;
	logic [3:0]                  dig_q [b2d_pkg::NUM_DIG];
	logic [3:0]                  dig_nx [b2d_pkg::NUM_DIG];
	logic [b2d_pkg::CNT_W-1:0]   cnt_q;
	logic [b2d_pkg::PTR_W-1:0]   ptr_q;
	logic [b2d_pkg::PTR_W-1:0]   start_idx;
	logic [b2d_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;
	logic [3:0]                  cur_dig;
	logic [b2d_pkg::CHAR_W-1:0]  char_nx;

	// one double-dabble step: adjust every digit, then shift the binary msb in
	always_comb begin
		logic [3:0] adj [b2d_pkg::NUM_DIG];
		for (int i = 0; i < b2d_pkg::NUM_DIG; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
		dig_nx[0] = {adj[0][2:0], bin_q[b2d_pkg::VALUE_W-1]};
		for (int i = 1; i < b2d_pkg::NUM_DIG; i++) begin
			dig_nx[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// highest nonzero digit, no lower than the ones or the whole-seconds digit
	always_comb begin
		logic [b2d_pkg::PTR_W-1:0] low;
		low = cmd.time_mode ? b2d_pkg::PTR_W'(b2d_pkg::FRAC_DIG) : '0;
		start_idx = low;
		for (int i = 0; i < b2d_pkg::NUM_DIG; i++) begin
			if (dig_q[i] != 4'd0 && b2d_pkg::PTR_W'(i) >= low) begin
				start_idx = b2d_pkg::PTR_W'(i);
			end
		end
	end

	assign cur_dig = (ptr_q < b2d_pkg::PTR_W'(b2d_pkg::NUM_DIG)) ? dig_q[ptr_q] : 4'd0;

	always_comb begin
		unique case (cmd.out_kind)
			b2d_pkg::KIND_DIGIT: char_nx = b2d_pkg::CHAR_ZERO | {4'd0, cur_dig};
			b2d_pkg::KIND_DOT:   char_nx = b2d_pkg::CHAR_DOT;
			b2d_pkg::KIND_NL:    char_nx = b2d_pkg::CHAR_NL;
			default:             char_nx = b2d_pkg::CHAR_NL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.conv_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.ptr_start) begin
				ptr_q <= start_idx;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			for (int i = 0; i < b2d_pkg::NUM_DIG; i++) begin
				dig_q[i] <= 4'd0;
			end
		end else if (cmd.conv_step) begin
			bin_q <= {bin_q[b2d_pkg::VALUE_W-2:0], 1'b0};
			for (int i = 0; i < b2d_pkg::NUM_DIG; i++) begin
				dig_q[i] <= dig_nx[i];
			end
		end
		if (cmd.out_load) begin
			char_q <= char_nx;
			last_q <= cmd.out_last;
		end
	end

	assign status.conv_last   = (cnt_q == {b2d_pkg::CNT_W{1'b1}});
	assign status.ptr_int_end = (ptr_q == b2d_pkg::PTR_W'(b2d_pkg::FRAC_DIG));
	assign status.ptr_zero    = (ptr_q == '0);
	assign text_char          = char_q;
	assign last_char          = last_q;

endmodule

FILE: src/b2d_ctrl.sv
// controller: sequences conversion and character emission, holds the format register
`timescale 1ns / 1ps

module b2d_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    out_ready,
	output logic                    out_valid,
	input  logic                    cfg_valid,
	input  logic                    cfg_bit,
	input  b2d_pkg::dp_status_t     status,
	output b2d_pkg::dp_cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_INT,
		ST_DOT,
		ST_FRAC,
		ST_NL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   time_fmt_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.time_mode = time_fmt_q;
		cmd.out_kind  = b2d_pkg::KIND_DIGIT;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_CONV: cmd.conv_step = 1'b1;
			ST_SCAN: cmd.ptr_start = 1'b1;
			ST_INT: begin
				cmd.out_load = slot_free;
				cmd.ptr_dec  = slot_free;
				cmd.out_last = !time_fmt_q && status.ptr_zero;
			end
			ST_DOT: begin
				cmd.out_load = slot_free;
				cmd.out_kind = b2d_pkg::KIND_DOT;
			end
			ST_FRAC: begin
				cmd.out_load = slot_free;
				cmd.ptr_dec  = slot_free;
			end
			ST_NL: begin
				cmd.out_load = slot_free;
				cmd.out_kind = b2d_pkg::KIND_NL;
				cmd.out_last = 1'b1;
			end
			default: cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			time_fmt_q  <= 1'b1;
		end else begin
			if (cfg_valid) begin
				time_fmt_q <= cfg_bit;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CONV;
				ST_CONV: if (status.conv_last) state_q <= ST_SCAN;
				ST_SCAN: state_q <= ST_INT;
				ST_INT: begin
					if (slot_free) begin
						if (time_fmt_q && status.ptr_int_end) begin
							state_q <= ST_DOT;
						end else if (!time_fmt_q && status.ptr_zero) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DOT: if (slot_free) state_q <= ST_FRAC;
				ST_FRAC: if (slot_free && status.ptr_zero) state_q <= ST_NL;
				ST_NL: if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: src/binary_to_decimal_text_emitter_unit.sv
// Converts one unsigned 32-bit value per input item into decimal ASCII text,
// most significant character first, with m_tlast on the final character.
// time_format 0 gives the plain integer without leading zeros; time_format 1
// (reset value) shows the value as milliseconds in seconds, "s.fff" with at
// least one integer digit, followed by a newline. One value is handled at a
// time: after acceptance a shift-add bcd conversion runs over all 32 bits, a
// scan state picks the first digit, then one character per cycle leaves
// through the output register while m_tready is high, for 1 to 12 characters
// per item; s_tready returns once the last character is loaded and may rise
// while that character still waits on the output.
// Write time_format only while no conversion or emission is under way.
`timescale 1ns / 1ps
`include "binary_to_decimal_text_emitter_unit_defines.svh"

module binary_to_decimal_text_emitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] text_char
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data    // [0] time_format
);

	b2d_pkg::dp_cmd_t    cmd;
	b2d_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	b2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.cfg_valid (cfg_valid),
		.cfg_bit   (cfg_data[0]),
		.status    (status),
		.cmd       (cmd)
	);

	b2d_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.text_char (m_tdata),
		.last_char (m_tlast)
	);

	// a value is accepted only when the block is idle, and conversion follows
	`B2D_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input accepted while converting")

	// every emitted character is a digit, a dot or a newline
	`B2D_ASSERT_NOW(a_char_set, clk, arst_n, m_tvalid, (m_tdata[7:4] == 4'h3 && m_tdata[3:0] <= 4'd9) || m_tdata == b2d_pkg::CHAR_DOT || m_tdata == b2d_pkg::CHAR_NL, "illegal output character")

	// a newline always closes a run and a dot never does
	`B2D_ASSERT_NOW(a_nl_last, clk, arst_n, m_tvalid && m_tdata == b2d_pkg::CHAR_NL, m_tlast, "newline not flagged last")

	`B2D_ASSERT_NOW(a_dot_not_last, clk, arst_n, m_tvalid && m_tdata == b2d_pkg::CHAR_DOT, !m_tlast, "dot flagged last")

endmodule
